@@ rtl/rsig_pkg.sv @@
// Shared types and constants for the ring stitch index generator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package rsig_pkg;

  // Field and register widths.
  localparam int SIZE_W     = 11;  // ring size, start position, segment count
  localparam int TRI_W      = 12;  // triangle counter, holds up to 4094
  localparam int BASE_W     = 16;  // ring base index
  localparam int IDX_W      = 17;  // emitted vertex index
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = $clog2(SIZE_W);  // remainder unit step counter

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_BASE    = 3'd0,
    CFG_BOTTOM_BASE = 3'd1,
    CFG_TOP_SIZE    = 3'd2,
    CFG_BOTTOM_SIZE = 3'd3,
    CFG_CLOSED      = 3'd4,
    CFG_FILLED      = 3'd5
  } cfg_idx_e;

  // Request action codes.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } act_e;

  // Ring codes used by the triangle tables.
  localparam logic RING_BOTTOM = 1'b0;
  localparam logic RING_TOP    = 1'b1;

  // Triangle shape per advancing side: which ring each corner comes from and
  // whether the corner uses the next position on that ring.
  // Side 0 (bottom advances): B[p], T[q], B[p+1].
  // Side 1 (top advances):    T[q+1], B[p], T[q].
  localparam logic TRI_SELECT [2][3] = '{
    '{RING_BOTTOM, RING_TOP, RING_BOTTOM},
    '{RING_TOP, RING_BOTTOM, RING_TOP}
  };
  localparam logic TRI_OFFSET [2][3] = '{
    '{1'b0, 1'b0, 1'b1},
    '{1'b1, 1'b0, 1'b0}
  };

  // Commands from the core to one ring position keeper.
  typedef struct packed {
    logic              size_wr;    // ring size register write
    logic              start;      // load a new start position
    logic              adv;        // step to the next position
    logic [SIZE_W-1:0] size;       // raw size value being written
    logic [SIZE_W-1:0] start_pos;  // raw start position
  } ring_cmd_t;

  // Status from one ring position keeper.
  typedef struct packed {
    logic              busy;  // a position reduction is pending or running
    logic [SIZE_W-1:0] eff;   // effective ring size (1 .. RING_MAX)
  } ring_stat_t;

endpackage

`default_nettype wire

@@ rtl/rsig_in_if.sv @@
// Request channel of the ring stitch index generator: valid/ready handshake
// carrying one action with segment counts and start positions. Uses rsig_pkg.
`default_nettype none

interface rsig_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [rsig_pkg::SIZE_W-1:0] top_count;
  logic [rsig_pkg::SIZE_W-1:0] bottom_count;
  logic [rsig_pkg::SIZE_W-1:0] top_start;
  logic [rsig_pkg::SIZE_W-1:0] bottom_start;

  modport source (
    output valid, action, top_count, bottom_count, top_start, bottom_start,
    input  ready
  );
  modport sink (
    input  valid, action, top_count, bottom_count, top_start, bottom_start,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/rsig_out_if.sv @@
// Result channel of the ring stitch index generator: valid/ready handshake
// carrying three vertex indices and the last-triangle flag. Uses rsig_pkg.
`default_nettype none

interface rsig_out_if;
  logic                       valid;
  logic                       ready;
  logic [rsig_pkg::IDX_W-1:0] index_a;
  logic [rsig_pkg::IDX_W-1:0] index_b;
  logic [rsig_pkg::IDX_W-1:0] index_c;
  logic                       last;

  modport source (
    output valid, index_a, index_b, index_c, last,
    input  ready
  );
  modport sink (
    input  valid, index_a, index_b, index_c, last,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/rsig_mod_unit.sv @@
// Bit-serial remainder unit: x mod d for 11-bit operands, one quotient bit
// per cycle (restoring). Depends on rsig_pkg for widths.
`default_nettype none

module rsig_mod_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rsig_pkg::SIZE_W-1:0] x_i,
  input  logic [rsig_pkg::SIZE_W-1:0] d_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [rsig_pkg::SIZE_W-1:0] rem_o
);

  logic                        run_q;
  logic                        done_q;
  logic [rsig_pkg::STEP_W-1:0] cnt_q;
  logic [rsig_pkg::SIZE_W-1:0] x_q;
  logic [rsig_pkg::SIZE_W-1:0] d_q;
  logic [rsig_pkg::SIZE_W-1:0] r_q;

  logic [rsig_pkg::SIZE_W:0]   r_shift;
  logic [rsig_pkg::SIZE_W:0]   d_ext;
  logic [rsig_pkg::SIZE_W-1:0] r_d;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  // The partial remainder stays below d, so one subtract is enough.
  always_comb begin
    r_shift = {r_q, x_q[rsig_pkg::SIZE_W-1]};
    d_ext   = {1'b0, d_q};
    if (r_shift >= d_ext) begin
      r_d = rsig_pkg::SIZE_W'(r_shift - d_ext);
    end else begin
      r_d = rsig_pkg::SIZE_W'(r_shift);
    end
  end

  // Control: run flag, step counter and one-cycle done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= rsig_pkg::STEP_W'(rsig_pkg::SIZE_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      d_q <= d_i;
      r_q <= '0;
    end else if (run_q) begin
      x_q <= x_q << 1;
      r_q <= r_d;
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

@@ rtl/rsig_ring_ctrl.sv @@
// Position keeper for one ring: effective size register, stored and reduced
// positions, and the remainder unit that wraps them. Uses rsig_pkg and
// rsig_mod_unit.
`default_nettype none

module rsig_ring_ctrl #(
  parameter int RING_MAX = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rsig_pkg::ring_cmd_t         cmd_i,
  output rsig_pkg::ring_stat_t        stat_o,
  output logic [$clog2(RING_MAX)-1:0] pos_o,
  output logic [$clog2(RING_MAX)-1:0] pos_nxt_o
);

  localparam int PosW = $clog2(RING_MAX);

  logic [rsig_pkg::SIZE_W-1:0] eff_q;
  logic [rsig_pkg::SIZE_W-1:0] eff_d;
  logic [PosW-1:0]             raw_q;   // position as last set by start or step
  logic [PosW-1:0]             red_q;   // raw position mod current size
  logic                        stale_q; // size changed, reduction pending
  logic                        job_start_q;

  logic                        mod_start;
  logic                        mod_busy;
  logic                        mod_done;
  logic [rsig_pkg::SIZE_W-1:0] mod_x;
  logic [rsig_pkg::SIZE_W-1:0] mod_rem;
  logic                        launch_red;
  logic [PosW:0]               pos_inc;

  // Effective size: zero counts as one, large sizes saturate.
  always_comb begin
    if (cmd_i.size == '0) begin
      eff_d = rsig_pkg::SIZE_W'(1);
    end else if (32'(cmd_i.size) > RING_MAX) begin
      eff_d = rsig_pkg::SIZE_W'(RING_MAX);
    end else begin
      eff_d = cmd_i.size;
    end
  end

  // A start takes the unit at once; a pending reduction waits for it idle.
  assign launch_red = stale_q && !mod_busy && !mod_done && !cmd_i.start;
  assign mod_start  = cmd_i.start || launch_red;
  assign mod_x      = cmd_i.start ? cmd_i.start_pos : rsig_pkg::SIZE_W'(raw_q);

  rsig_mod_unit u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (mod_x),
    .d_i     (eff_q),
    .busy_o  (mod_busy),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // Next position with wrap at the ring size.
  always_comb begin
    pos_inc = {1'b0, red_q} + 1'b1;
    if (32'(pos_inc) == 32'(eff_q)) begin
      pos_nxt_o = '0;
    end else begin
      pos_nxt_o = PosW'(pos_inc);
    end
  end

  // Size, positions and reduction bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q       <= rsig_pkg::SIZE_W'(1);
      raw_q       <= '0;
      red_q       <= '0;
      stale_q     <= 1'b0;
      job_start_q <= 1'b0;
    end else begin
      if (cmd_i.size_wr) begin
        eff_q <= eff_d;
      end
      if (cmd_i.size_wr) begin
        stale_q <= 1'b1;
      end else if (launch_red) begin
        stale_q <= 1'b0;
      end
      if (mod_start) begin
        job_start_q <= cmd_i.start;
      end
      if (cmd_i.adv) begin
        raw_q <= pos_nxt_o;
        red_q <= pos_nxt_o;
      end else if (mod_done) begin
        red_q <= PosW'(mod_rem);
        if (job_start_q) begin
          raw_q <= PosW'(mod_rem);
        end
      end
    end
  end

  assign pos_o       = red_q;
  assign stat_o.busy = mod_busy || mod_done || stale_q;
  assign stat_o.eff  = eff_q;

endmodule

`default_nettype wire

@@ rtl/ring_stitch_index_generator_core.sv @@
// Ring stitch index generator: emits triangle vertex indices that stitch a
// top and a bottom vertex ring. Uses rsig_pkg, rsig_in_if, rsig_out_if and
// rsig_ring_ctrl.
//
// Usage: write the six configuration registers through cfg_we_i/cfg_idx_i/
// cfg_wdata_i while the block is idle. Then send a start request (action 0)
// with the segment counts and start positions, followed by step requests
// (action 1). Each step with a triangle left gives one result on out_o; the
// final triangle of the segment carries last. Steps beyond that are dropped.
// A request is registered on entry and its result on exit. Steps sustain
// one request per cycle while the receiver takes results and no ring
// position is being reduced. A start request wraps both start positions in
// a bit-serial remainder unit per ring, which holds the next request until
// both are done; a ring size write triggers the same reduction of the
// stored position, during which requests wait.
// Reset clears flags, counters and positions; registers return to base 0,
// ring sizes 1, closed strip, not filled. No clearing pass is needed.
// When the receiver stalls, the result register holds and one more request
// waits in the input register; ready drops when both are full or while a
// request waits for a ring position to be reduced.
`default_nettype none

module ring_stitch_index_generator_core #(
  parameter int RING_MAX = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsig_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsig_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  rsig_in_if.sink                         in_i,
  rsig_out_if.source                      out_o
);

  localparam int PosW = $clog2(RING_MAX);

  // Configuration registers held here (sizes live in the ring keepers).
  logic [rsig_pkg::BASE_W-1:0] top_base_q;
  logic [rsig_pkg::BASE_W-1:0] bot_base_q;
  logic                        closed_q;
  logic                        filled_q;

  // Input register.
  logic                        s1_valid_q;
  logic                        s1_act_q;
  logic [rsig_pkg::SIZE_W-1:0] s1_tc_q;
  logic [rsig_pkg::SIZE_W-1:0] s1_bc_q;
  logic [rsig_pkg::SIZE_W-1:0] s1_ts_q;
  logic [rsig_pkg::SIZE_W-1:0] s1_bs_q;

  // Segment state.
  logic [rsig_pkg::TRI_W-1:0]  tri_left_q;
  logic                        side_q;
  logic                        heavy_q;
  logic [rsig_pkg::SIZE_W-1:0] num_b_q;
  logic [rsig_pkg::SIZE_W-1:0] num_t_q;
  logic [rsig_pkg::SIZE_W-1:0] seg_tc_q;
  logic [rsig_pkg::SIZE_W-1:0] seg_bc_q;

  // Result register.
  logic                        out_valid_q;
  logic [rsig_pkg::IDX_W-1:0]  out_a_q;
  logic [rsig_pkg::IDX_W-1:0]  out_b_q;
  logic [rsig_pkg::IDX_W-1:0]  out_c_q;
  logic                        out_last_q;

  rsig_pkg::ring_cmd_t         top_cmd;
  rsig_pkg::ring_cmd_t         bot_cmd;
  rsig_pkg::ring_stat_t        top_stat;
  rsig_pkg::ring_stat_t        bot_stat;
  logic [PosW-1:0]             top_pos;
  logic [PosW-1:0]             top_nxt;
  logic [PosW-1:0]             bot_pos;
  logic [PosW-1:0]             bot_nxt;

  logic                        s1_adv;
  logic                        in_fire;
  logic                        is_start;
  logic                        is_step;
  logic                        emit;

  logic [rsig_pkg::IDX_W-1:0]  vidx [3];
  logic [rsig_pkg::TRI_W-1:0]  tri_total;
  logic [rsig_pkg::TRI_W-1:0]  tri_less;
  logic [rsig_pkg::TRI_W-1:0]  tri_init;
  logic [rsig_pkg::SIZE_W-1:0] frac_inc;
  logic [rsig_pkg::SIZE_W-1:0] frac_den;
  logic [rsig_pkg::SIZE_W-1:0] frac_num;
  logic [rsig_pkg::SIZE_W:0]   frac_sum;
  logic [rsig_pkg::SIZE_W-1:0] frac_new;
  logic                        frac_wrap;

  // Handshake: the input register moves on when both rings are settled and
  // the result register is free or being emptied.
  assign s1_adv     = s1_valid_q && !top_stat.busy && !bot_stat.busy &&
                      (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_start   = s1_adv && (s1_act_q == rsig_pkg::ACT_START);
  assign is_step    = s1_adv && (s1_act_q == rsig_pkg::ACT_STEP);
  assign emit       = is_step && (tri_left_q != '0);

  // Ring position keepers.
  always_comb begin
    top_cmd.size_wr   = cfg_we_i && (cfg_idx_i == rsig_pkg::CFG_TOP_SIZE);
    top_cmd.start     = is_start;
    top_cmd.adv       = emit && (side_q == rsig_pkg::RING_TOP);
    top_cmd.size      = rsig_pkg::SIZE_W'(cfg_wdata_i);
    top_cmd.start_pos = s1_ts_q;
    bot_cmd.size_wr   = cfg_we_i && (cfg_idx_i == rsig_pkg::CFG_BOTTOM_SIZE);
    bot_cmd.start     = is_start;
    bot_cmd.adv       = emit && (side_q == rsig_pkg::RING_BOTTOM);
    bot_cmd.size      = rsig_pkg::SIZE_W'(cfg_wdata_i);
    bot_cmd.start_pos = s1_bs_q;
  end

  rsig_ring_ctrl #(.RING_MAX(RING_MAX)) u_top_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (top_cmd),
    .stat_o    (top_stat),
    .pos_o     (top_pos),
    .pos_nxt_o (top_nxt)
  );

  rsig_ring_ctrl #(.RING_MAX(RING_MAX)) u_bot_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (bot_cmd),
    .stat_o    (bot_stat),
    .pos_o     (bot_pos),
    .pos_nxt_o (bot_nxt)
  );

  // Triangle corners: ring base plus current or next wrapped position.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (rsig_pkg::TRI_SELECT[side_q][j] == rsig_pkg::RING_TOP) begin
        vidx[j] = rsig_pkg::IDX_W'(top_base_q) + rsig_pkg::IDX_W'(
                  rsig_pkg::TRI_OFFSET[side_q][j] ? top_nxt : top_pos);
      end else begin
        vidx[j] = rsig_pkg::IDX_W'(bot_base_q) + rsig_pkg::IDX_W'(
                  rsig_pkg::TRI_OFFSET[side_q][j] ? bot_nxt : bot_pos);
      end
    end
  end

  // Triangle count for a new segment, floored at zero.
  always_comb begin
    tri_total = rsig_pkg::TRI_W'(s1_tc_q) + rsig_pkg::TRI_W'(s1_bc_q);
    if (!closed_q) begin
      tri_less = rsig_pkg::TRI_W'(2);
    end else if (filled_q) begin
      tri_less = rsig_pkg::TRI_W'(1);
    end else begin
      tri_less = '0;
    end
    tri_init = (tri_total > tri_less) ? (tri_total - tri_less) : '0;
  end

  // Fractional stepper: the heavier ring's count sets the denominator. The
  // numerator stays below the denominator, so one subtract wraps it.
  always_comb begin
    if (side_q == rsig_pkg::RING_BOTTOM) begin
      frac_inc = heavy_q ? seg_tc_q : rsig_pkg::SIZE_W'(1);
      frac_den = heavy_q ? seg_bc_q : rsig_pkg::SIZE_W'(1);
      frac_num = num_b_q;
    end else begin
      frac_inc = heavy_q ? rsig_pkg::SIZE_W'(1) : seg_bc_q;
      frac_den = heavy_q ? rsig_pkg::SIZE_W'(1) : seg_tc_q;
      frac_num = num_t_q;
    end
    if (frac_den == '0) begin
      frac_den = rsig_pkg::SIZE_W'(1);
    end
    frac_sum  = {1'b0, frac_num} + {1'b0, frac_inc};
    frac_wrap = frac_sum >= {1'b0, frac_den};
    frac_new  = frac_wrap ? rsig_pkg::SIZE_W'(frac_sum - {1'b0, frac_den})
                          : rsig_pkg::SIZE_W'(frac_sum);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_base_q <= '0;
      bot_base_q <= '0;
      closed_q   <= 1'b1;
      filled_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (rsig_pkg::cfg_idx_e'(cfg_idx_i))
        rsig_pkg::CFG_TOP_BASE:    top_base_q <= cfg_wdata_i;
        rsig_pkg::CFG_BOTTOM_BASE: bot_base_q <= cfg_wdata_i;
        rsig_pkg::CFG_CLOSED:      closed_q   <= cfg_wdata_i[0];
        rsig_pkg::CFG_FILLED:      filled_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register valid and segment state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      tri_left_q <= '0;
      side_q     <= rsig_pkg::RING_BOTTOM;
      heavy_q    <= 1'b0;
      num_b_q    <= '0;
      num_t_q    <= '0;
      seg_tc_q   <= '0;
      seg_bc_q   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (is_start) begin
        tri_left_q <= tri_init;
        seg_tc_q   <= s1_tc_q;
        seg_bc_q   <= s1_bc_q;
        heavy_q    <= s1_bc_q > s1_tc_q;
        side_q     <= !(s1_bc_q > s1_tc_q);
        num_b_q    <= '0;
        num_t_q    <= '0;
      end else if (emit) begin
        tri_left_q <= tri_left_q - 1'b1;
        if (frac_wrap) begin
          side_q <= !side_q;
        end
        if (side_q == rsig_pkg::RING_BOTTOM) begin
          num_b_q <= frac_new;
        end else begin
          num_t_q <= frac_new;
        end
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_act_q <= in_i.action;
      s1_tc_q  <= in_i.top_count;
      s1_bc_q  <= in_i.bottom_count;
      s1_ts_q  <= in_i.top_start;
      s1_bs_q  <= in_i.bottom_start;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_a_q    <= vidx[0];
      out_b_q    <= vidx[1];
      out_c_q    <= vidx[2];
      out_last_q <= (tri_left_q == rsig_pkg::TRI_W'(1));
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.index_a = out_a_q;
  assign out_o.index_b = out_b_q;
  assign out_o.index_c = out_c_q;
  assign out_o.last    = out_last_q;

  // A settled ring always holds a wrapped position.
  a_top_pos_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !top_stat.busy |-> (32'(top_pos) < 32'(top_stat.eff)))
    else $error("top ring position not below its ring size");

  a_bot_pos_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bot_stat.busy |-> (32'(bot_pos) < 32'(bot_stat.eff)))
    else $error("bottom ring position not below its ring size");

  // The last flag is set exactly when the segment runs out of triangles.
  a_last_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q && (out_last_q == (tri_left_q == '0)))
    else $error("last flag disagrees with the triangle counter");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for ring_stitch_index_generator_core: random and directed
// segments are driven over the request channel and each triangle is checked
// against a local stitch predictor. Needs the core, rsig_pkg, rsig_in_if and rsig_out_if.

module tb;

  localparam int RING_LIMIT = 1024;
  localparam int PHASE_ITEMS = 210;

  typedef struct packed {
    rsig_pkg::act_e              action;
    logic [rsig_pkg::SIZE_W-1:0] top_count;
    logic [rsig_pkg::SIZE_W-1:0] bottom_count;
    logic [rsig_pkg::SIZE_W-1:0] top_start;
    logic [rsig_pkg::SIZE_W-1:0] bottom_start;
  } stitch_req_t;

  typedef struct packed {
    logic [rsig_pkg::IDX_W-1:0] idx_a;
    logic [rsig_pkg::IDX_W-1:0] idx_b;
    logic [rsig_pkg::IDX_W-1:0] idx_c;
    logic                       last;
  } triangle_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [rsig_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [rsig_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rsig_in_if  req_if ();
  rsig_out_if tri_if ();

  ring_stitch_index_generator_core #(
    .RING_MAX(RING_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (req_if),
    .out_o      (tri_if)
  );

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Pending requests, expected triangles and run bookkeeping.
  stitch_req_t pending_requests[$];
  triangle_t   expected_tris[$];
  int          queued_cnt = 0;
  int          accepted_cnt = 0;
  int          checked_cnt = 0;
  int          starts_seen = 0;
  int          settings_cnt = 0;
  int          mismatches = 0;
  int          budget_left = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  // Register copies as written to the block.
  logic [rsig_pkg::BASE_W-1:0] top_base_r = '0;
  logic [rsig_pkg::BASE_W-1:0] bot_base_r = '0;
  logic [rsig_pkg::SIZE_W-1:0] top_size_r = rsig_pkg::SIZE_W'(1);
  logic [rsig_pkg::SIZE_W-1:0] bot_size_r = rsig_pkg::SIZE_W'(1);
  logic                        closed_r = 1'b1;
  logic                        filled_r = 1'b0;

  // Segment state of the stitch predictor.
  logic [rsig_pkg::TRI_W-1:0]  tris_left = '0;
  logic [9:0]                  top_pos = '0;
  logic [9:0]                  bot_pos = '0;
  logic                        adv_top = 1'b0;
  logic                        bot_heavy = 1'b0;
  logic [rsig_pkg::SIZE_W-1:0] frac_bot = '0;
  logic [rsig_pkg::SIZE_W-1:0] frac_top = '0;
  logic [rsig_pkg::SIZE_W-1:0] seg_top = '0;
  logic [rsig_pkg::SIZE_W-1:0] seg_bot = '0;

  // Wrap modulus that a raw ring size register stands for.
  function automatic int unsigned ring_span(logic [rsig_pkg::SIZE_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > RING_LIMIT) return RING_LIMIT;
    return raw;
  endfunction

  function automatic logic [rsig_pkg::IDX_W-1:0] corner(logic [rsig_pkg::BASE_W-1:0] base,
                                                        int unsigned pos, int unsigned span);
    return rsig_pkg::IDX_W'(base + pos % span);
  endfunction

  // Advance the predictor by one accepted request; a step with a triangle
  // left adds the expected triangle.
  task automatic stitch_predict(stitch_req_t r);
    int unsigned tspan, bspan, total, trim, inc, den, num;
    triangle_t   t;
    logic        from_top;
    tspan = ring_span(top_size_r);
    bspan = ring_span(bot_size_r);
    if (r.action == rsig_pkg::ACT_START) begin
      total = r.top_count + r.bottom_count;
      trim = closed_r ? (filled_r ? 1 : 0) : 2;
      tris_left = (total > trim) ? rsig_pkg::TRI_W'(total - trim) : '0;
      seg_top = r.top_count;
      seg_bot = r.bottom_count;
      top_pos = 10'(r.top_start % tspan);
      bot_pos = 10'(r.bottom_start % bspan);
      bot_heavy = r.bottom_count > r.top_count;
      adv_top = !bot_heavy;
      frac_bot = '0;
      frac_top = '0;
      starts_seen++;
    end else if (tris_left != '0) begin
      from_top = adv_top;
      if (!from_top) begin
        t.idx_a = corner(bot_base_r, bot_pos, bspan);
        t.idx_b = corner(top_base_r, top_pos, tspan);
        t.idx_c = corner(bot_base_r, bot_pos + 1, bspan);
      end else begin
        t.idx_a = corner(top_base_r, top_pos + 1, tspan);
        t.idx_b = corner(bot_base_r, bot_pos, bspan);
        t.idx_c = corner(top_base_r, top_pos, tspan);
      end
      t.last = (tris_left == 1);
      tris_left = tris_left - 1'b1;
      expected_tris = {expected_tris, t};

      // The fractional stepper decides when the other ring takes over.
      if (!from_top) begin
        bot_pos = 10'((bot_pos + 1) % bspan);
        inc = bot_heavy ? seg_top : 1;
        den = bot_heavy ? seg_bot : 1;
        num = frac_bot;
      end else begin
        top_pos = 10'((top_pos + 1) % tspan);
        inc = bot_heavy ? 1 : seg_bot;
        den = bot_heavy ? 1 : seg_top;
        num = frac_top;
      end
      if (den == 0) den = 1;
      num = num + inc;
      if (num >= den) begin
        num = num % den;
        adv_top = !from_top;
      end
      if (!from_top) begin
        frac_bot = rsig_pkg::SIZE_W'(num);
      end else begin
        frac_top = rsig_pkg::SIZE_W'(num);
      end
    end
  endtask

  // Request driver with random idle bursts.
  always @(posedge clk_i) begin : drive_requests
    stitch_req_t taken;
    stitch_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.action <= rsig_pkg::ACT_START;
      req_if.top_count <= '0;
      req_if.bottom_count <= '0;
      req_if.top_start <= '0;
      req_if.bottom_start <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken.action = rsig_pkg::act_e'(req_if.action);
        taken.top_count = req_if.top_count;
        taken.bottom_count = req_if.bottom_count;
        taken.top_start = req_if.top_start;
        taken.bottom_start = req_if.bottom_start;
        stitch_predict(taken);
        accepted_cnt++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          nxt = pending_requests.pop_front();
          req_if.valid <= 1'b1;
          req_if.action <= nxt.action;
          req_if.top_count <= nxt.top_count;
          req_if.bottom_count <= nxt.bottom_count;
          req_if.top_start <= nxt.top_start;
          req_if.bottom_start <= nxt.bottom_start;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Triangle monitor with random stall bursts.
  always @(posedge clk_i) begin : watch_triangles
    triangle_t want;
    if (!rst_ni) begin
      tri_if.ready <= 1'b0;
    end else begin
      if (tri_if.valid && tri_if.ready) begin
        if (expected_tris.size() == 0) begin
          $display("%0t: unexpected triangle, expected none, actual %0d %0d %0d last %0d",
                   $time, tri_if.index_a, tri_if.index_b, tri_if.index_c, tri_if.last);
          mismatches++;
        end else begin
          want = expected_tris.pop_front();
          report_field("index_a", want.idx_a, tri_if.index_a);
          report_field("index_b", want.idx_b, tri_if.index_b);
          report_field("index_c", want.idx_c, tri_if.index_c);
          report_field("last", want.last, tri_if.last);
          checked_cnt++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        tri_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        tri_if.ready <= 1'b0;
      end else begin
        tri_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_request(rsig_pkg::act_e action, int unsigned tc, int unsigned bc,
                               int unsigned ts, int unsigned bs);
    stitch_req_t r;
    r.action = action;
    r.top_count = rsig_pkg::SIZE_W'(tc);
    r.bottom_count = rsig_pkg::SIZE_W'(bc);
    r.top_start = rsig_pkg::SIZE_W'(ts);
    r.bottom_start = rsig_pkg::SIZE_W'(bs);
    pending_requests = {pending_requests, r};
    queued_cnt++;
  endtask

  // Steps carry random content in the fields they do not use.
  task automatic queue_steps(int unsigned n);
    repeat (n) begin
      queue_request(rsig_pkg::ACT_STEP, $urandom_range(0, 1024), $urandom_range(0, 1024),
                    $urandom_range(0, 2047), $urandom_range(0, 2047));
    end
  endtask

  // One segment: a start and its steps, sometimes cut short, sometimes with
  // surplus steps that the block drops. Now and then a stray request first.
  task automatic queue_random_segment();
    int unsigned tc, bc, tmp, steps, pick, extra;
    if ($urandom_range(0, 19) == 0) begin
      queue_request(rsig_pkg::act_e'($urandom_range(0, 1)), $urandom_range(0, 1024),
                    $urandom_range(0, 1024), $urandom_range(0, 2047), $urandom_range(0, 2047));
      budget_left--;
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      tc = $urandom_range(0, 8);
      bc = $urandom_range(0, 8);
    end else if (pick < 92) begin
      tc = $urandom_range(0, 40);
      bc = $urandom_range(0, 40);
    end else begin
      tc = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(512, 1024);
      bc = $urandom_range(0, 1024);
      if ($urandom_range(0, 1) == 1) begin
        tmp = tc;
        tc = bc;
        bc = tmp;
      end
    end
    queue_request(rsig_pkg::ACT_START, tc, bc, $urandom_range(0, 2047), $urandom_range(0, 2047));
    steps = tc + bc;
    if (steps > 60) steps = $urandom_range(0, 60);
    else if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
    queue_steps(steps);
    extra = $urandom_range(0, 2);
    queue_steps(extra);
    budget_left -= 1 + steps + extra;
  endtask

  // Continue whatever segment is open, then random segments.
  task automatic queue_random_phase();
    budget_left = PHASE_ITEMS - 3;
    queue_steps(3);
    while (budget_left > 0) queue_random_segment();
  endtask

  // Wait until every request is taken and every triangle seen, then let the
  // remainder units settle.
  task automatic drain();
    while (accepted_cnt != queued_cnt || pending_requests.size() != 0 ||
           expected_tris.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(rsig_pkg::cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= rsig_pkg::CFG_DATA_W'(val);
    case (idx)
      rsig_pkg::CFG_TOP_BASE:    top_base_r = rsig_pkg::BASE_W'(val);
      rsig_pkg::CFG_BOTTOM_BASE: bot_base_r = rsig_pkg::BASE_W'(val);
      rsig_pkg::CFG_TOP_SIZE:    top_size_r = rsig_pkg::SIZE_W'(val);
      rsig_pkg::CFG_BOTTOM_SIZE: bot_size_r = rsig_pkg::SIZE_W'(val);
      rsig_pkg::CFG_CLOSED:      closed_r = val[0];
      rsig_pkg::CFG_FILLED:      filled_r = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic program_rings(int unsigned tb_base, int unsigned bb_base, int unsigned tsz,
                               int unsigned bsz, int unsigned closed, int unsigned filled);
    drain();
    write_reg(rsig_pkg::CFG_TOP_BASE, tb_base);
    write_reg(rsig_pkg::CFG_BOTTOM_BASE, bb_base);
    write_reg(rsig_pkg::CFG_TOP_SIZE, tsz);
    write_reg(rsig_pkg::CFG_BOTTOM_SIZE, bsz);
    write_reg(rsig_pkg::CFG_CLOSED, closed);
    write_reg(rsig_pkg::CFG_FILLED, filled);
    settings_cnt++;
  endtask

  function automatic int unsigned random_size();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 1024);
  endfunction

  // Main sequence: reset, directed segments, then random phases.
  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a step before any start, then a short segment with an
    // oversized start position and one surplus step.
    queue_steps(1);
    queue_request(rsig_pkg::ACT_START, 3, 2, 2047, 0);
    queue_steps(6);

    // Largest bases and rings, closed and filled.
    program_rings(16'hFFFF, 16'hFFFF, 1024, 1024, 1, 1);
    // Empty segment, and a segment that the filled fan trims to nothing.
    queue_request(rsig_pkg::ACT_START, 0, 0, 0, 0);
    queue_steps(1);
    queue_request(rsig_pkg::ACT_START, 1, 0, 0, 0);
    queue_steps(1);
    // Bottom ring heavier, full segment plus two surplus steps.
    queue_request(rsig_pkg::ACT_START, 2, 5, 0, 1000);
    queue_steps(8);
    // Largest counts, start positions at the wrap; left open on purpose so
    // that the next phase continues it under new ring sizes.
    queue_request(rsig_pkg::ACT_START, 1024, 1024, 1023, 2047);
    queue_steps(4);

    // Size zero and a size above the ring limit, open strip.
    program_rings(0, 0, 0, 2047, 0, 0);
    queue_random_phase();
    program_rings($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(1, 16), $urandom_range(1, 16), 0, 1);
    queue_random_phase();
    program_rings($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(1, 1024), $urandom_range(1, 1024), 1, 0);
    queue_random_phase();
    program_rings($urandom_range(0, 65535), $urandom_range(0, 65535), 1, 1024, 1, 1);
    queue_random_phase();
    for (int p = 0; p < 4; p++) begin
      program_rings($urandom_range(0, 65535), $urandom_range(0, 65535), random_size(),
                    random_size(), $urandom_range(0, 1), $urandom_range(0, 1));
      // The final phase runs without idling on either side.
      if (p == 3) calm = 1'b1;
      queue_random_phase();
    end
    drain();

    $display("Ran %0d requests with %0d segment starts under %0d register settings;",
             accepted_cnt, starts_seen, settings_cnt);
    $display("%0d triangles checked, %0d mismatches.", checked_cnt, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
